>>> sv/assert_macros.svh
// assertion macros shared by the union-find rtl
// no dependencies; included by the files that carry checks

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define UFPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define UFPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ufpc_pkg.sv
// shared types and constants for the union-find table with path compression
// no dependencies; imported by ufpc_ctrl and the top level

package ufpc_pkg;

	// width of a run index on the ports
	localparam int unsigned IDX_W = 10;

	// request operation codes
	typedef enum logic [1:0] {
		OP_MAKE  = 2'd0,
		OP_FIND  = 2'd1,
		OP_UNION = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_FIX,
		ST_FEND,
		ST_RESP
	} state_t;

	// one result, handed from the sequencer to the output register
	typedef struct packed {
		logic [IDX_W-1:0] representative;
		logic             found;
		logic             status;
	} res_t;

endpackage

>>> sv/ufpc_table.sv
// entry table: one write port and one registered read port
// no dependencies; each word holds the in-set mark above the parent index

module ufpc_table #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned DW = 11,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/ufpc_ctrl.sv
// sequencer for make set, find with path compression and union
// depends on ufpc_pkg and assert_macros.svh; drives the ufpc_table ports

`include "assert_macros.svh"

module ufpc_ctrl #(
	parameter int unsigned RUN_ENTRIES = 1024,
	localparam int unsigned IW = $clog2(RUN_ENTRIES)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request side
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ufpc_pkg::op_t                     in_op,
	input  logic [ufpc_pkg::IDX_W-1:0]        in_a,
	input  logic [ufpc_pkg::IDX_W-1:0]        in_b,
	// result side
	output logic                              res_valid,
	input  logic                              res_ready,
	output ufpc_pkg::res_t                    res,
	// table ports
	output logic                              mem_we,
	output logic [IW-1:0]                     mem_waddr,
	output logic [IW:0]                       mem_wdata,
	output logic                              mem_re,
	output logic [IW-1:0]                     mem_raddr,
	input  logic [IW:0]                       mem_rdata
);

	import ufpc_pkg::*;

	state_t          state_q, state_d;
	op_t             op_q;
	logic [IDX_W-1:0] a_q, b_q;
	logic [IW-1:0]   start_q, start_d;
	logic [IW-1:0]   cur_q, cur_d;
	logic [IW-1:0]   node_q, node_d;
	logic [IW-1:0]   ra_q, ra_d;
	logic [IW-1:0]   clr_q;
	logic            ok_q, ok_d;
	logic            oka_q, oka_d;
	logic            phase_q, phase_d;
	res_t            res_q, res_d;

	// walk start index and its range check
	logic [IDX_W-1:0]    walk_idx10;
	logic [IW+IDX_W-1:0] walk_ext;
	logic [IW-1:0]       walk_idx;
	logic                walk_in;
	logic                rd_mark;
	logic [IW-1:0]       rd_par;
	logic                walk_end;
	logic [IW+IDX_W-1:0] cur_ext;
	logic [IDX_W-1:0]    cur_rep;
	logic                clr_last;

	assign walk_idx10 = (state_q == ST_FEND) ? b_q : a_q;
	assign walk_ext   = {{IW{1'b0}}, walk_idx10};
	assign walk_idx   = walk_ext[IW-1:0];
	assign walk_in    = walk_ext < (IW+IDX_W)'(RUN_ENTRIES);
	assign rd_mark    = mem_rdata[IW];
	assign rd_par     = mem_rdata[IW-1:0];
	assign walk_end   = !rd_mark || (rd_par == cur_q);
	assign cur_ext    = {{IDX_W{1'b0}}, cur_q};
	assign cur_rep    = cur_ext[IDX_W-1:0];
	assign clr_last   = clr_q == IW'(RUN_ENTRIES - 1);
	assign res        = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				unique case (op_q)
					OP_FIND, OP_UNION: state_d = walk_in ? ST_WALK : ST_FEND;
					default:           state_d = ST_RESP;
				endcase
			end
			ST_WALK: begin
				if (walk_end) state_d = (start_q == cur_q) ? ST_FEND : ST_FIX;
			end
			ST_FIX: begin
				if (rd_par == cur_q) state_d = ST_FEND;
			end
			ST_FEND: begin
				if (op_q == OP_UNION && !phase_q) begin
					state_d = walk_in ? ST_WALK : ST_FEND;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and table port outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_START: begin
				if (op_q == OP_MAKE && walk_in) begin
					mem_we    = 1'b1;
					mem_waddr = walk_idx;
					mem_wdata = {1'b1, walk_idx};
				end else if ((op_q == OP_FIND || op_q == OP_UNION) && walk_in) begin
					mem_re    = 1'b1;
					mem_raddr = walk_idx;
				end
			end
			ST_WALK: begin
				if (!walk_end) begin
					mem_re    = 1'b1;
					mem_raddr = rd_par;
				end else if (start_q != cur_q) begin
					mem_re    = 1'b1;
					mem_raddr = start_q;
				end
			end
			ST_FIX: begin
				// relink to the root on success, drop the mark on failure
				mem_we    = 1'b1;
				mem_waddr = node_q;
				mem_wdata = ok_q ? {1'b1, cur_q} : {1'b0, rd_par};
				if (rd_par != cur_q) begin
					mem_re    = 1'b1;
					mem_raddr = rd_par;
				end
			end
			ST_FEND: begin
				if (op_q == OP_UNION && !phase_q) begin
					if (walk_in) begin
						mem_re    = 1'b1;
						mem_raddr = walk_idx;
					end
				end else if (op_q == OP_UNION && oka_q && ok_q) begin
					mem_we    = 1'b1;
					mem_waddr = ra_q;
					mem_wdata = {1'b1, cur_q};
				end
			end
			ST_RESP: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// walk datapath next values
	always_comb begin
		start_d = start_q;
		cur_d   = cur_q;
		node_d  = node_q;
		ra_d    = ra_q;
		ok_d    = ok_q;
		oka_d   = oka_q;
		phase_d = phase_q;
		res_d   = res_q;
		unique case (state_q)
			ST_START: begin
				phase_d = 1'b0;
				start_d = walk_idx;
				cur_d   = walk_idx;
				ok_d    = 1'b0;
				res_d   = '0;
				if (op_q == OP_MAKE) begin
					res_d.status         = !walk_in;
					res_d.found          = walk_in;
					res_d.representative = walk_in ? a_q : '0;
				end
			end
			ST_WALK: begin
				if (!rd_mark) begin
					ok_d = 1'b0;
				end else if (rd_par == cur_q) begin
					ok_d = 1'b1;
				end else begin
					cur_d = rd_par;
				end
				node_d = start_q;
			end
			ST_FIX: begin
				node_d = rd_par;
			end
			ST_FEND: begin
				if (op_q == OP_UNION && !phase_q) begin
					phase_d = 1'b1;
					oka_d   = ok_q;
					ra_d    = cur_q;
					start_d = walk_idx;
					cur_d   = walk_idx;
					ok_d    = 1'b0;
				end else if (ok_q && (op_q == OP_FIND || oka_q)) begin
					res_d.status         = 1'b0;
					res_d.found          = 1'b1;
					res_d.representative = cur_rep;
				end else begin
					res_d.status         = 1'b1;
					res_d.found          = 1'b0;
					res_d.representative = '0;
				end
			end
			default: begin
				res_d = res_q;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q <= in_op;
			a_q  <= in_a;
			b_q  <= in_b;
		end
		start_q <= start_d;
		cur_q   <= cur_d;
		node_q  <= node_d;
		ra_q    <= ra_d;
		ok_q    <= ok_d;
		oka_q   <= oka_d;
		phase_q <= phase_d;
		res_q   <= res_d;
	end

	// checks
	`UFPC_ASSERT_IMP(a_port_clash, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr, "table read and write at one entry")
	`UFPC_ASSERT_IMP(a_found_ok, clk, arst_n, res_valid, !(res.found && res.status), "found result with error status")
	`UFPC_ASSERT_IMP(a_rep_zero, clk, arst_n, res_valid && !res.found, res.representative == '0, "nonzero representative without a root")
	`UFPC_ASSERT_IMP(a_fix_node, clk, arst_n, state_q == ST_FIX, node_q != cur_q, "rewrite pass reached the walk end")

endmodule

>>> sv/union_find_path_compression.sv
// make set writes its entry directly; find walks the links, then rewrites each entry it passed;
// union runs both walks, and the root link write shares the final walk-end state with the result
// throughput: one request at a time; every link costs a registered table read
// after reset a clearing pass over all RUN_ENTRIES entries clears all marks, no request taken
// output register lets the next request in while a result waits
// depends on ufpc_pkg, ufpc_ctrl and ufpc_table

module union_find_path_compression #(
	parameter int unsigned RUN_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // run_a [9:0], run_b [19:10], zero [23:20]
	input  logic [1:0]  s_tuser,   // operation [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // representative [9:0], zero [15:10]
	output logic [1:0]  m_tuser    // status [0], found [1]
);

	import ufpc_pkg::*;

	localparam int unsigned IW = $clog2(RUN_ENTRIES);

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	res_t          out_q;
	logic          out_valid_q;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [IW:0]   mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic [IW:0]   mem_rdata;

	// sequencer
	ufpc_ctrl #(
		.RUN_ENTRIES(RUN_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (op_t'(s_tuser)),
		.in_a     (s_tdata[9:0]),
		.in_b     (s_tdata[19:10]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// mark and parent table
	ufpc_table #(
		.DEPTH(RUN_ENTRIES),
		.DW   (IW + 1)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.representative};
	assign m_tuser  = {out_q.found, out_q.status};

endmodule

>>> sim/tb_union_find_path_compression.sv
// self-checking bench for the union-find table with path compression
// holds its own table model and scores every result against it in order
// depends on ufpc_pkg and union_find_path_compression

module tb_union_find_path_compression;
	timeunit 1ns;
	timeprecision 1ps;

	import ufpc_pkg::*;

	localparam int ENTRIES = 1024;

	// one queued request
	typedef struct {
		op_t              op;
		logic [IDX_W-1:0] run_a;
		logic [IDX_W-1:0] run_b;
		bit               calm;    // no gap after this request
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // run_a [9:0], run_b [19:10], zero [23:20]
	logic [1:0]  s_tuser = '0;     // operation [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // representative [9:0], zero [15:10]
	logic [1:0]  m_tuser;          // status [0], found [1]

	// table copy kept by the bench
	logic [IDX_W-1:0] link_to [ENTRIES];
	bit               in_set [ENTRIES];

	request_t    pending [$];
	res_t        owed_results [$];
	request_t    tx_item;
	int          tx_gap = 0;
	int          rx_stall = 0;
	int          mode_left = 0;
	bit          rx_steady = 1'b0;
	int unsigned req_count = 0;
	int unsigned res_count = 0;
	int unsigned total_reqs = 0;
	int          hold_left = 0;
	int unsigned holds_done = 0;
	int unsigned errors = 0;

	union_find_path_compression uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// walk to the root, then compress the path or clear marks on failure
	function automatic bit chase_root(input logic [IDX_W-1:0] start,
	                                  output logic [IDX_W-1:0] root);
		logic [IDX_W-1:0] cur;
		logic [IDX_W-1:0] nxt;
		logic [IDX_W-1:0] node;
		int hops;
		bit ok;
		cur = start;
		hops = 0;
		ok = 1'b0;
		while (1) begin
			if (!in_set[cur])
				break;
			nxt = link_to[cur];
			if (nxt == cur) begin
				ok = 1'b1;
				break;
			end
			if (hops >= ENTRIES)
				break;
			hops++;
			cur = nxt;
		end
		// second pass over the same path
		node = start;
		for (int n = 0; n < hops; n++) begin
			if (!in_set[node])
				break;
			nxt = link_to[node];
			if (ok)
				link_to[node] = cur;
			else
				in_set[node] = 1'b0;
			node = nxt;
		end
		if (!ok && in_set[node] && link_to[node] != node)
			in_set[node] = 1'b0;
		root = ok ? cur : '0;
		return ok;
	endfunction

	// apply one request to the table copy and return its result
	function automatic res_t apply_request(input op_t op, input logic [IDX_W-1:0] a,
	                                       input logic [IDX_W-1:0] b);
		res_t res;
		logic [IDX_W-1:0] ra;
		logic [IDX_W-1:0] rb;
		bit oka;
		bit okb;
		res = '0;
		case (op)
			OP_MAKE: begin
				link_to[a] = a;
				in_set[a] = 1'b1;
				res.found = 1'b1;
				res.representative = a;
			end
			OP_FIND: begin
				if (chase_root(a, ra)) begin
					res.found = 1'b1;
					res.representative = ra;
				end else begin
					res.status = 1'b1;
				end
			end
			OP_UNION: begin
				oka = chase_root(a, ra);
				okb = chase_root(b, rb);
				if (oka && okb) begin
					link_to[ra] = rb;
					res.found = 1'b1;
					res.representative = rb;
				end else begin
					res.status = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic queue_request(input op_t op, input int a, input int b, input bit calm);
		request_t r;
		r.op = op;
		r.run_a = a[IDX_W-1:0];
		r.run_b = b[IDX_W-1:0];
		r.calm = calm;
		pending.push_back(r);
	endtask

	// request driver: predicts on acceptance, then offers the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				owed_results.push_back(apply_request(op_t'(s_tuser), s_tdata[9:0],
					s_tdata[19:10]));
				req_count <= req_count + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0) begin
					tx_item = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= tx_item.op;
					s_tdata <= {4'b0000, tx_item.run_b, tx_item.run_a};
					tx_gap = tx_item.calm ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-offs so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && req_count >= 100) ||
		             (holds_done == 1 && req_count >= 400)) begin
			hold_left <= 300;
			holds_done <= holds_done + 1;
		end
	end

	// result monitor: scores each result, then sets the next ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				res_count <= res_count + 1;
				if (owed_results.size() == 0) begin
					report("unexpected result, representative", m_tdata[9:0], 0);
				end else begin
					if (m_tuser[0] !== owed_results[0].status)
						report("status", m_tuser[0], owed_results[0].status);
					if (m_tuser[1] !== owed_results[0].found)
						report("found", m_tuser[1], owed_results[0].found);
					if (m_tdata[9:0] !== owed_results[0].representative)
						report("representative", m_tdata[9:0],
							owed_results[0].representative);
					void'(owed_results.pop_front());
				end
			end
			// alternate stretches of steady ready and random stalls
			if (mode_left == 0) begin
				rx_steady = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			if (rx_stall > 0)
				rx_stall--;
			else if (!rx_steady)
				rx_stall = pick_gap();
			m_tready <= (hold_left == 0) && (rx_stall == 0);
		end
	end

	// stimulus and end of run
	initial begin
		int pool [64];
		int psize;
		int nops;
		int r;
		bit calm;

		// directed: extremes, every operation, failing walks and unions
		queue_request(OP_MAKE, 0, 1023, 1'b0);
		queue_request(OP_MAKE, 1023, 0, 1'b0);
		queue_request(OP_FIND, 1023, 1023, 1'b0);
		queue_request(OP_FIND, 682, 341, 1'b0);
		queue_request(OP_UNION, 0, 1023, 1'b0);
		queue_request(OP_FIND, 0, 682, 1'b0);
		queue_request(OP_UNION, 0, 1023, 1'b0);
		queue_request(OP_UNION, 341, 0, 1'b0);
		queue_request(OP_UNION, 0, 341, 1'b0);
		queue_request(OP_NONE, 1023, 1023, 1'b0);
		queue_request(OP_NONE, 0, 0, 1'b0);
		// chain of three links, then compress it
		queue_request(OP_MAKE, 10, 5, 1'b1);
		queue_request(OP_MAKE, 11, 5, 1'b1);
		queue_request(OP_MAKE, 12, 5, 1'b1);
		queue_request(OP_MAKE, 13, 5, 1'b1);
		queue_request(OP_UNION, 10, 11, 1'b1);
		queue_request(OP_UNION, 11, 12, 1'b1);
		queue_request(OP_UNION, 12, 13, 1'b0);
		queue_request(OP_FIND, 10, 0, 1'b0);
		queue_request(OP_MAKE, 12, 0, 1'b0);
		queue_request(OP_FIND, 11, 0, 1'b0);
		queue_request(OP_UNION, 13, 10, 1'b0);

		// random phases: well-formed sets built from a small pool, some noise
		while (pending.size() < 650) begin
			psize = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
				$urandom_range(3, 16);
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < psize; i++)
				pool[i] = $urandom_range(0, ENTRIES - 1);
			for (int i = 0; i < psize; i++)
				if ($urandom_range(0, 9) != 0)
					queue_request(OP_MAKE, pool[i], $urandom_range(0, 1023), calm);
			nops = $urandom_range(psize, 3 * psize);
			for (int j = 0; j < nops; j++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					queue_request(OP_UNION, pool[$urandom_range(0, psize - 1)],
						pool[$urandom_range(0, psize - 1)], calm);
				else if (r < 80)
					queue_request(OP_FIND, pool[$urandom_range(0, psize - 1)],
						$urandom_range(0, 1023), calm);
				else if (r < 88)
					queue_request(OP_MAKE, pool[$urandom_range(0, psize - 1)],
						$urandom_range(0, 1023), calm);
				else if (r < 92)
					queue_request(OP_FIND, $urandom_range(0, 1023),
						$urandom_range(0, 1023), calm);
				else if (r < 96)
					queue_request(OP_UNION, $urandom_range(0, 1023),
						pool[$urandom_range(0, psize - 1)], calm);
				else
					queue_request(OP_NONE, $urandom_range(0, 1023),
						$urandom_range(0, 1023), calm);
			end
		end
		total_reqs = pending.size();

		// reset, then let the driver and monitor run
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every request has come back as a result
		while (res_count < total_reqs)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("** union_find_path_compression: PASSED **");
		else
			$display("** union_find_path_compression: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#50ms;
		$display("** union_find_path_compression: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/ufpc_pkg.sv
sv/ufpc_table.sv
sv/ufpc_ctrl.sv
sv/union_find_path_compression.sv
sim/tb_union_find_path_compression.sv
